### hdl/amge_pkg.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph engine package
// Field widths, command codes, and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package amge_pkg;

    // Field widths fixed by the port list.
    localparam int CMD_W  = 3;
    localparam int NODE_W = 6;
    localparam int DEG_W  = 7;
    localparam int CNT_W  = 7;

    // Command codes carried on the command field.
    localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ASK_MARKED = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ASK_CLEAN  = 3'd5;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic accept;      // latch the input word and read row node_a
        logic capture_a;   // take row node_a and its degree into the working registers
        logic apply_load;  // apply the load cell update to the working row
        logic idx_from_b;  // scan index starts at node_b
        logic idx_zero;    // scan index starts at zero
        logic step;        // one scan step on the working row, read row at the index
        logic idx_inc;     // advance the scan index
        logic write_i;     // write back the row at the scan index with node_a removed
        logic write_a;     // write back the working row and degree of node_a
        logic finish;      // register the result word
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             err;       // index check on the incoming word failed
        logic [CMD_W-1:0] command;   // latched command code
        logic             bit_set;   // working row has the bit at the scan index
        logic             self_idx;  // scan index equals node_a
        logic             last;      // scan index is the final one for this command
    } t_dp_stat;

    // Degree decrement that stops at zero.
    function automatic logic [DEG_W-1:0] f_deg_dec(input logic [DEG_W-1:0] deg);
        return (deg == '0) ? deg : deg - DEG_W'(1);
    endfunction

endpackage

### hdl/amge_ctrl.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph engine controller
// Sequences each command through the read, update, edge scan and write back
// steps that its code needs, and drives the datapath with one strobe word per cycle.
// ----------------------------------------------------------------------------
module amge_ctrl
    import amge_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_A,
        S_APPLY,
        S_STEP,
        S_RD_I,
        S_WRITE_A,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath strobes.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.err ? S_FINISH : S_LOAD_A;
                end
            end
            S_LOAD_A: begin
                o_cmd.capture_a = 1'b1;
                if (i_stat.command == CMD_LOAD) begin
                    n_state = S_APPLY;
                end else if (i_stat.command == CMD_REMOVE) begin
                    o_cmd.idx_from_b = 1'b1;
                    n_state          = S_STEP;
                end else if (i_stat.command == CMD_DISCONNECT) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_STEP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_APPLY: begin
                o_cmd.apply_load = 1'b1;
                n_state          = S_WRITE_A;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_stat.bit_set && !i_stat.self_idx) begin
                    n_state = S_RD_I;
                end else if (i_stat.last) begin
                    n_state = S_WRITE_A;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_RD_I: begin
                o_cmd.write_i = 1'b1;
                if (i_stat.last) begin
                    n_state = S_WRITE_A;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_STEP;
                end
            end
            S_WRITE_A: begin
                o_cmd.write_a = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/amge_dp.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph engine datapath
// Holds the row and degree memory, the mark bits, the node count register,
// the working copy of row node_a and the registered result word.
// ----------------------------------------------------------------------------
module amge_dp
    import amge_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_edge_value,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic              o_marked,
    output logic              o_all_neighbours_marked,
    output logic              o_edge_present,
    output logic [DEG_W-1:0]  o_degree,
    output logic              o_error
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int MW = MAX_NODES + DEG_W;

    // Row and degree memory with one valid bit per entry; an entry never
    // written reads as all zero.
    logic [MW-1:0]        mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_valid;
    logic [MW-1:0]        r_rd_data;
    logic                 r_rd_valid;

    logic [CNT_W-1:0]     r_node_count;
    logic [CMD_W-1:0]     r_cmd;
    logic [NODE_W-1:0]    r_a;
    logic [NODE_W-1:0]    r_b;
    logic                 r_v;
    logic                 r_err;
    logic [MAX_NODES-1:0] r_row_a;
    logic [DEG_W-1:0]     r_deg_a;
    logic [MAX_NODES-1:0] r_mark;
    logic [AW-1:0]        r_idx;
    logic                 r_done;
    logic                 r_marked;
    logic                 r_all_clean;
    logic                 r_edge;
    logic [DEG_W-1:0]     r_degree;
    logic                 r_error;

    logic [CNT_W-1:0]     eff;
    logic                 in_err;
    logic [AW-1:0]        a_idx;
    logic [AW-1:0]        b_idx;
    logic [AW-1:0]        rd_addr;
    logic [MW-1:0]        rd_word;
    logic [MAX_NODES-1:0] rd_row;
    logic [DEG_W-1:0]     rd_deg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MW-1:0]        wr_data;
    logic [MAX_NODES-1:0] in_mask;
    logic                 b_in_range;

    // Effective node count and the index check on the incoming word.
    assign eff    = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign in_err = ({1'b0, i_node_a} >= eff) ||
                    (((i_command == CMD_LOAD) || (i_command == CMD_REMOVE)) &&
                     ({1'b0, i_node_b} >= eff));

    assign a_idx = r_a[AW-1:0];
    assign b_idx = r_b[AW-1:0];

    // Status toward the controller.
    assign o_stat.err      = in_err;
    assign o_stat.command  = r_cmd;
    assign o_stat.bit_set  = r_row_a[r_idx];
    assign o_stat.self_idx = (r_idx == a_idx);
    assign o_stat.last     = (r_cmd == CMD_REMOVE) ||
                             ((CNT_W'(r_idx) + CNT_W'(1)) == eff);

    // Memory read and write ports.
    assign rd_addr = i_cmd.accept ? i_node_a[AW-1:0] : r_idx;
    assign rd_word = r_rd_valid ? r_rd_data : '0;
    assign rd_row  = rd_word[MAX_NODES-1:0];
    assign rd_deg  = rd_word[MW-1:MAX_NODES];

    assign wr_en   = i_cmd.write_a || i_cmd.write_i;
    assign wr_addr = i_cmd.write_a ? a_idx : r_idx;
    always_comb begin
        if (i_cmd.write_a) begin
            wr_data = {r_deg_a, r_row_a};
        end else begin
            wr_data = {f_deg_dec(rd_deg), rd_row & ~(MAX_NODES'(1) << a_idx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.accept || i_cmd.step) begin
            r_rd_data  <= mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    // Mask of the node indices in use.
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            in_mask[i] = (CNT_W'(i) < eff);
        end
    end

    assign b_in_range = ({1'b0, r_b} < eff);

    // Control state: valid bits, mark bits, node count and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_mark       <= '0;
            r_node_count <= CNT_W'(64);
            r_done       <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.capture_a && (r_cmd == CMD_MARK)) begin
                r_mark[a_idx] <= 1'b1;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            r_done <= i_cmd.finish;
        end
    end

    // Working registers for the command in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_a   <= i_node_a;
            r_b   <= i_node_b;
            r_v   <= i_edge_value;
            r_err <= in_err;
        end
        if (i_cmd.capture_a) begin
            r_row_a <= rd_row;
            r_deg_a <= rd_deg;
        end else if (i_cmd.apply_load) begin
            // A set bit raises the degree, a cleared bit lowers it.
            if (r_v && !r_row_a[b_idx]) begin
                r_row_a[b_idx] <= 1'b1;
                if (r_deg_a < DEG_W'(MAX_NODES)) begin
                    r_deg_a <= r_deg_a + DEG_W'(1);
                end
            end else if (!r_v && r_row_a[b_idx]) begin
                r_row_a[b_idx] <= 1'b0;
                r_deg_a        <= f_deg_dec(r_deg_a);
            end
        end else if (i_cmd.step && r_row_a[r_idx]) begin
            // A self loop counts against the degree of node_a twice.
            r_row_a[r_idx] <= 1'b0;
            if (r_idx == a_idx) begin
                r_deg_a <= f_deg_dec(f_deg_dec(r_deg_a));
            end else begin
                r_deg_a <= f_deg_dec(r_deg_a);
            end
        end
        if (i_cmd.idx_from_b) begin
            r_idx <= b_idx;
        end else if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_err) begin
                r_marked    <= 1'b0;
                r_all_clean <= 1'b0;
                r_edge      <= 1'b0;
                r_degree    <= '0;
                r_error     <= 1'b1;
            end else begin
                r_marked    <= r_mark[a_idx];
                r_all_clean <= ~|(r_row_a & ~r_mark & in_mask);
                r_edge      <= b_in_range && r_row_a[b_idx];
                r_degree    <= r_deg_a;
                r_error     <= 1'b0;
            end
        end
    end

    assign o_done                  = r_done;
    assign o_marked                = r_marked;
    assign o_all_neighbours_marked = r_all_clean;
    assign o_edge_present          = r_edge;
    assign o_degree                = r_degree;
    assign o_error                 = r_error;

endmodule

### hdl/adjacency_matrix_graph_engine.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph engine
// Adjacency bit matrix, per-node degree counts and mark bits, driven by
// load, remove, disconnect, mark and query commands.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. Its one result
// word appears on the result ports for exactly one cycle with o_done high;
// the receiver cannot stall, so it must take the word in that cycle. o_busy
// is already low in the cycle in which o_done is high, so a new command may be
// accepted while the previous result is shown. Busy time is set by the row
// memory and the node-by-node scan: an index error goes straight to the
// result, mark and the queries only read row node_a, load cell rewrites it,
// remove edge may also rewrite row node_b, and disconnect scans every node in
// use, rewriting each neighbor of node_a but itself. Reset clears the matrix,
// degrees and marks at once and sets the node count to 64. The node count
// register is written through i_cfg_valid / o_cfg_ready and takes a word only
// while no command is in flight and no command is being started.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_engine
    import amge_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_edge_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic              o_marked,
    output logic              o_all_neighbours_marked,
    output logic              o_edge_present,
    output logic [DEG_W-1:0]  o_degree,
    output logic              o_error
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     busy;

    // Command sequencer.
    amge_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // Matrix storage and result logic.
    amge_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (dp_cmd),
        .o_stat                  (dp_stat),
        .i_command               (i_command),
        .i_node_a                (i_node_a),
        .i_node_b                (i_node_b),
        .i_edge_value            (i_edge_value),
        .i_cfg_valid             (i_cfg_valid),
        .i_cfg_ready             (o_cfg_ready),
        .i_cfg_data              (i_cfg_data),
        .o_done                  (o_done),
        .o_marked                (o_marked),
        .o_all_neighbours_marked (o_all_neighbours_marked),
        .o_edge_present          (o_edge_present),
        .o_degree                (o_degree),
        .o_error                 (o_error)
    );

    // The node count only changes between commands, never at the edge that
    // takes a new command.
    assign o_busy      = busy;
    assign o_cfg_ready = !busy && !i_start;

endmodule

### sim/adjacency_matrix_graph_engine_test.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph engine testbench
// Drives load, remove, disconnect, mark and query commands through the start
// and busy handshake, predicts every result word from a local copy of the
// matrix, degrees and marks, and checks each word as its done strobe shows.
// A short directed table comes first, then random phases under several node
// counts, from zero and one up to values beyond the matrix size.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_engine_test
    import amge_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES    = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DIRECTED_LEN = 29;
    localparam int PHASE_COUNT  = 10;

    // Codes outside the defined command set; the block treats them as queries.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // One result word as seen on the result ports.
    typedef struct packed {
        logic             marked;
        logic             all_neighbours_marked;
        logic             edge_present;
        logic [DEG_W-1:0] degree;
        logic             error;
    } t_graph_result;

    typedef enum logic [1:0] {
        ROW_CMD,
        ROW_CMD_TYPED,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: a command word or a node count write.
    typedef struct packed {
        t_row_kind         kind;
        logic [CNT_W-1:0]  cfg_value;
        logic [CMD_W-1:0]  command;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              edge_value;
        t_graph_result     typed;
    } t_stim_row;

    localparam t_graph_result RES_NONE = '0;
    localparam t_graph_result RES_IDLE_NODE = '{marked: 1'b0, all_neighbours_marked: 1'b1,
        edge_present: 1'b0, degree: '0, error: 1'b0};
    localparam t_graph_result RES_FIRST_EDGE = '{marked: 1'b0, all_neighbours_marked: 1'b0,
        edge_present: 1'b1, degree: 7'd1, error: 1'b0};
    localparam t_graph_result RES_INDEX_ERROR = '{marked: 1'b0, all_neighbours_marked: 1'b0,
        edge_present: 1'b0, degree: '0, error: 1'b1};

    // Directed table. Rows with a typed result are checked against that word.
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{ROW_CMD_TYPED, 7'd0, CMD_ASK_MARKED, 6'd0, 6'd0, 1'b0, RES_IDLE_NODE},
        '{ROW_CMD_TYPED, 7'd0, CMD_ASK_CLEAN, 6'd63, 6'd63, 1'b1, RES_IDLE_NODE},
        '{ROW_CMD_TYPED, 7'd0, CMD_LOAD, 6'd0, 6'd63, 1'b1, RES_FIRST_EDGE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd0, 6'd63, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd63, 6'd0, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_MARK, 6'd63, 6'd0, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_ASK_CLEAN, 6'd0, 6'd63, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd5, 6'd5, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_REMOVE, 6'd5, 6'd5, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_REMOVE, 6'd0, 6'd63, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_REMOVE, 6'd0, 6'd63, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd1, 6'd2, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd1, 6'd1, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd3, 6'd1, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd1, 6'd3, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_DISCONNECT, 6'd1, 6'd3, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd9, 6'd10, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd9, 6'd10, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_LOAD, 6'd7, 6'd8, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_SPARE_6, 6'd63, 6'd0, 1'b1, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_SPARE_7, 6'd0, 6'd63, 1'b0, RES_NONE},
        '{ROW_CFG, 7'd1, CMD_LOAD, 6'd0, 6'd0, 1'b0, RES_NONE},
        '{ROW_CMD_TYPED, 7'd0, CMD_LOAD, 6'd0, 6'd1, 1'b1, RES_INDEX_ERROR},
        '{ROW_CMD_TYPED, 7'd0, CMD_ASK_MARKED, 6'd1, 6'd0, 1'b0, RES_INDEX_ERROR},
        '{ROW_CMD, 7'd0, CMD_ASK_CLEAN, 6'd0, 6'd63, 1'b0, RES_NONE},
        '{ROW_CFG, 7'd0, CMD_LOAD, 6'd0, 6'd0, 1'b0, RES_NONE},
        '{ROW_CMD_TYPED, 7'd0, CMD_MARK, 6'd0, 6'd0, 1'b0, RES_INDEX_ERROR},
        '{ROW_CFG, 7'd127, CMD_LOAD, 6'd0, 6'd0, 1'b0, RES_NONE},
        '{ROW_CMD, 7'd0, CMD_ASK_MARKED, 6'd63, 6'd0, 1'b0, RES_NONE}
    };

    // Node count for each random phase; the entry of phase 8 is replaced by a
    // random value between 3 and 63.
    localparam logic [CNT_W-1:0] PHASE_COUNTS [PHASE_COUNT] = '{
        7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd37, 7'd64, 7'd100, 7'd20, 7'd64
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [CMD_W-1:0]  i_command;
    logic [NODE_W-1:0] i_node_a;
    logic [NODE_W-1:0] i_node_b;
    logic              i_edge_value;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              o_done;
    logic              o_marked;
    logic              o_all_neighbours_marked;
    logic              o_edge_present;
    logic [DEG_W-1:0]  o_degree;
    logic              o_error;

    // Local copy of the graph state.
    logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
    logic [MAX_NODES-1:0] mark_mask;
    logic [DEG_W-1:0]     node_degree [MAX_NODES];
    logic [CNT_W-1:0]     node_count_reg;

    t_graph_result pending_results [$];
    t_graph_result oldest_result;

    int  fail_count;
    int  items_sent;
    int  errors_answered;
    int  disconnects;
    int  settings_used;
    int  top_degree;
    int  cycle_count;
    bit  gaps_allowed;
    bit  gaps_on;

    adjacency_matrix_graph_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_top (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (i_start),
        .o_busy                  (o_busy),
        .i_command               (i_command),
        .i_node_a                (i_node_a),
        .i_node_b                (i_node_b),
        .i_edge_value            (i_edge_value),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_data              (i_cfg_data),
        .o_done                  (o_done),
        .o_marked                (o_marked),
        .o_all_neighbours_marked (o_all_neighbours_marked),
        .o_edge_present          (o_edge_present),
        .o_degree                (o_degree),
        .o_error                 (o_error)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Node count in effect: the register value, limited to the matrix size.
    function automatic int unsigned live_nodes();
        return (node_count_reg > MAX_NODES) ? MAX_NODES : int'(node_count_reg);
    endfunction

    function automatic void lower_degree(input logic [NODE_W-1:0] node);
        if (node_degree[node] != '0) begin
            node_degree[node] = node_degree[node] - 1'b1;
        end
    endfunction

    // Clear an undirected edge if the forward bit is set; a self loop lowers
    // its own degree twice.
    function automatic void drop_edge(input logic [NODE_W-1:0] node_a,
                                      input logic [NODE_W-1:0] node_b);
        if (adj_rows[node_a][node_b]) begin
            adj_rows[node_a][node_b] = 1'b0;
            adj_rows[node_b][node_a] = 1'b0;
            lower_degree(node_a);
            lower_degree(node_b);
        end
    endfunction

    // Apply one command word to the local graph and return its result word.
    function automatic t_graph_result apply_command(input logic [CMD_W-1:0]  command,
                                                    input logic [NODE_W-1:0] node_a,
                                                    input logic [NODE_W-1:0] node_b,
                                                    input logic              edge_value);
        t_graph_result        res;
        int unsigned          n_live;
        bit                   uses_b;
        logic [MAX_NODES-1:0] live_mask;

        res       = '0;
        n_live    = live_nodes();
        uses_b    = (command == CMD_LOAD) || (command == CMD_REMOVE);
        live_mask = (n_live >= MAX_NODES) ? '1 : ((64'd1 << n_live) - 64'd1);

        // An index out of range changes nothing and answers with error alone.
        if ((node_a >= n_live) || (uses_b && (node_b >= n_live))) begin
            res.error = 1'b1;
            return res;
        end

        case (command)
            CMD_LOAD: begin
                if (edge_value && !adj_rows[node_a][node_b]) begin
                    adj_rows[node_a][node_b] = 1'b1;
                    if (node_degree[node_a] < MAX_NODES) begin
                        node_degree[node_a] = node_degree[node_a] + 1'b1;
                    end
                end else if (!edge_value && adj_rows[node_a][node_b]) begin
                    adj_rows[node_a][node_b] = 1'b0;
                    lower_degree(node_a);
                end
            end
            CMD_REMOVE: begin
                drop_edge(node_a, node_b);
            end
            CMD_DISCONNECT: begin
                for (int i = 0; i < n_live; i++) begin
                    drop_edge(node_a, NODE_W'(i));
                end
            end
            CMD_MARK: begin
                mark_mask[node_a] = 1'b1;
            end
            default: begin
            end
        endcase

        // Only neighbors below the live count take part in the clean test.
        res.marked                = mark_mask[node_a];
        res.all_neighbours_marked = ((adj_rows[node_a] & ~mark_mask & live_mask) == '0);
        res.edge_present          = (node_b < n_live) ? adj_rows[node_a][node_b] : 1'b0;
        res.degree                = node_degree[node_a];
        return res;
    endfunction

    // Send one command word, wait until it is taken, queue its result word,
    // and sometimes leave a short gap before the next one.
    task automatic send_command(input logic [CMD_W-1:0]  command,
                                input logic [NODE_W-1:0] node_a,
                                input logic [NODE_W-1:0] node_b,
                                input logic              edge_value,
                                input bit                typed_valid,
                                input t_graph_result     typed_result);
        t_graph_result predicted;

        i_start      <= 1'b1;
        i_command    <= command;
        i_node_a     <= node_a;
        i_node_b     <= node_b;
        i_edge_value <= edge_value;
        do @(posedge i_clk); while (o_busy !== 1'b0);

        predicted = apply_command(command, node_a, node_b, edge_value);
        pending_results = {pending_results, (typed_valid ? typed_result : predicted)};
        items_sent++;
        if (predicted.error) errors_answered++;
        if (command == CMD_DISCONNECT) disconnects++;
        if (int'(predicted.degree) > top_degree) top_degree = int'(predicted.degree);

        // Gaps come in stretches; some stretches run back to back.
        if (items_sent % 16 == 0) begin
            gaps_on = gaps_allowed && ($urandom_range(0, 2) != 0);
        end
        if (gaps_on && ($urandom_range(0, 99) < 30)) begin
            i_start      <= 1'b0;
            i_command    <= CMD_W'($urandom);
            i_node_a     <= NODE_W'($urandom);
            i_node_b     <= NODE_W'($urandom);
            i_edge_value <= 1'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold off new commands until every queued result word has come back.
    task automatic wait_for_results();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the node count register while the block is idle.
    task automatic set_node_count(input logic [CNT_W-1:0] value);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid    <= 1'b0;
        node_count_reg  = value;
        settings_used++;
    endtask

    function automatic logic [NODE_W-1:0] pick_node(input int unsigned n_live);
        int unsigned roll;

        roll = $urandom_range(0, 99);
        // A few indices anywhere, many in a small hot set, the rest in range.
        if ((n_live == 0) || (roll < 8)) return NODE_W'($urandom_range(0, 63));
        if (roll < 50) return NODE_W'($urandom_range(0, ((n_live < 8) ? n_live : 8) - 1));
        return NODE_W'($urandom_range(0, n_live - 1));
    endfunction

    // Check each result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && (o_done === 1'b1)) begin
            if (pending_results.size() == 0) begin
                $error("result word with no command waiting for it");
                fail_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_marked !== oldest_result.marked) begin
                    $error("marked: expected %0d, got %0d", oldest_result.marked, o_marked);
                    fail_count++;
                end
                if (o_all_neighbours_marked !== oldest_result.all_neighbours_marked) begin
                    $error("all_neighbours_marked: expected %0d, got %0d",
                           oldest_result.all_neighbours_marked, o_all_neighbours_marked);
                    fail_count++;
                end
                if (o_edge_present !== oldest_result.edge_present) begin
                    $error("edge_present: expected %0d, got %0d",
                           oldest_result.edge_present, o_edge_present);
                    fail_count++;
                end
                if (o_degree !== oldest_result.degree) begin
                    $error("degree: expected %0d, got %0d", oldest_result.degree, o_degree);
                    fail_count++;
                end
                if (o_error !== oldest_result.error) begin
                    $error("error: expected %0d, got %0d", oldest_result.error, o_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("adjacency_matrix_graph_engine_test: errors");
        $finish;
    end

    // Stimulus.
    initial begin
        t_stim_row         row;
        logic [CMD_W-1:0]  command;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] hub;
        logic [NODE_W-1:0] spoke;
        logic [CNT_W-1:0]  phase_count;
        int unsigned       n_live;
        int unsigned       roll;
        int                quota;
        int                phase_start;
        int                spokes;
        bit                full_row;
        bit                paused;

        // Known graph state after reset.
        for (int i = 0; i < MAX_NODES; i++) begin
            adj_rows[i]    = '0;
            node_degree[i] = '0;
        end
        mark_mask       = '0;
        node_count_reg  = 7'd64;
        fail_count      = 0;
        items_sent      = 0;
        errors_answered = 0;
        disconnects     = 0;
        settings_used   = 0;
        top_degree      = 0;
        gaps_allowed    = 1'b1;
        gaps_on         = 1'b1;
        paused          = 1'b0;

        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_command    <= '0;
        i_node_a     <= '0;
        i_node_b     <= '0;
        i_edge_value <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int r = 0; r < DIRECTED_LEN; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CFG) begin
                set_node_count(row.cfg_value);
            end else begin
                send_command(row.command, row.node_a, row.node_b, row.edge_value,
                             row.kind == ROW_CMD_TYPED, row.typed);
            end
        end

        // Random phases, one node count each; the last phase runs without gaps.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            phase_count = (ph == 8) ? CNT_W'($urandom_range(3, 63)) : PHASE_COUNTS[ph];
            set_node_count(phase_count);
            n_live       = live_nodes();
            quota        = (n_live == 0) ? 40 : 155;
            phase_start  = items_sent;
            gaps_allowed = (ph != PHASE_COUNT - 1);
            gaps_on      = gaps_allowed;

            // Build a star around one hub; in the first phase and with few
            // nodes the hub gets every column, which drives its degree to the top.
            if (n_live != 0) begin
                hub      = NODE_W'($urandom_range(0, n_live - 1));
                full_row = (ph == 0) || (n_live <= 16);
                spokes   = full_row ? int'(n_live) : 8;
                for (int s = 0; s < spokes; s++) begin
                    spoke = full_row ? NODE_W'(s) : NODE_W'($urandom_range(0, n_live - 1));
                    send_command(CMD_LOAD, hub, spoke, 1'b1, 1'b0, RES_NONE);
                    if (!full_row) send_command(CMD_LOAD, spoke, hub, 1'b1, 1'b0, RES_NONE);
                end
            end

            while (items_sent - phase_start < quota) begin
                roll   = $urandom_range(0, 99);
                node_a = pick_node(n_live);
                node_b = pick_node(n_live);
                if (roll < 10) begin
                    // Both directions of an edge, so removals find a real pair.
                    send_command(CMD_LOAD, node_a, node_b, 1'b1, 1'b0, RES_NONE);
                    send_command(CMD_LOAD, node_b, node_a, 1'b1, 1'b0, RES_NONE);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 28) command = CMD_LOAD;
                    else if (roll < 42) command = CMD_REMOVE;
                    else if (roll < 50) command = CMD_DISCONNECT;
                    else if (roll < 62) command = CMD_MARK;
                    else if (roll < 76) command = CMD_ASK_MARKED;
                    else if (roll < 92) command = CMD_ASK_CLEAN;
                    else command = roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
                    send_command(command, node_a, node_b, 1'($urandom), 1'b0, RES_NONE);
                end

                // Once in the run, let the block drain completely mid-phase.
                if ((ph == 5) && !paused && (items_sent - phase_start >= quota / 2)) begin
                    wait_for_results();
                    paused = 1'b1;
                end
            end
        end

        // Let the last result words come back, then give the block a margin.
        wait_for_results();
        repeat (2 * MAX_NODES + 8) @(posedge i_clk);

        $display("Sent %0d commands under %0d node count settings; %0d hit an index error.",
                 items_sent, settings_used, errors_answered);
        $display("Disconnects: %0d; highest degree predicted: %0d.", disconnects, top_degree);
        if (fail_count == 0) begin
            $display("adjacency_matrix_graph_engine_test: clean");
        end else begin
            $display("adjacency_matrix_graph_engine_test: errors");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/amge_pkg.sv
hdl/amge_ctrl.sv
hdl/amge_dp.sv
hdl/adjacency_matrix_graph_engine.sv
sim/adjacency_matrix_graph_engine_test.sv
